### src/assert_macros.svh
// Assertion helpers for the RTL; only hpt_ctrl includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication property checked at every rising edge outside reset.
`define HPT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true outside reset.
`define HPT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### src/hpt_pkg.sv
// ----------------------------------------------------------------------------
// hpt_pkg
// Shared constants and controller command bundle for the point transform.
// ----------------------------------------------------------------------------
package hpt_pkg;

    localparam int HPT_FRAC_BITS = 16;
    localparam int CMD_W         = 2;
    localparam int IDX_W         = 4;
    localparam int DATA_W        = 32;

    localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_VECTOR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POINT  = 2'd2;

    typedef struct packed {
        logic             load;
        logic             capture;
        logic             point;
        logic             mac_step;
        logic [IDX_W-1:0] mac_idx;
        logic             div_load;
        logic             div_step;
        logic             div_write;
        logic [1:0]       div_idx;
        logic             out_load;
    } hpt_cmd_t;

endpackage

### src/hpt_if.sv
// ----------------------------------------------------------------------------
// hpt_in_if / hpt_out_if
// Valid/ready channels carrying the input item and the result item.
// ----------------------------------------------------------------------------
interface hpt_in_if;
    import hpt_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic [IDX_W-1:0]         entry_index;
    logic signed [DATA_W-1:0] entry_value;
    logic signed [DATA_W-1:0] in_x;
    logic signed [DATA_W-1:0] in_y;
    logic signed [DATA_W-1:0] in_z;
    logic signed [DATA_W-1:0] in_w;

    modport source (output valid, cmd, entry_index, entry_value, in_x, in_y, in_z, in_w,
                    input ready);
    modport sink   (input valid, cmd, entry_index, entry_value, in_x, in_y, in_z, in_w,
                    output ready);
endinterface

interface hpt_out_if;
    import hpt_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] out_x;
    logic signed [DATA_W-1:0] out_y;
    logic signed [DATA_W-1:0] out_z;
    logic signed [DATA_W-1:0] out_w;
    logic                     range_error;

    modport source (output valid, out_x, out_y, out_z, out_w, range_error, input ready);
    modport sink   (input valid, out_x, out_y, out_z, out_w, range_error, output ready);
endinterface

### src/hpt_ctrl.sv
// ----------------------------------------------------------------------------
// hpt_ctrl
// Sequencer: 16 multiply-accumulate steps, then three serial divides for
// points, then hand-off to the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hpt_ctrl #(
    parameter int FRAC_BITS = hpt_pkg::HPT_FRAC_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [hpt_pkg::CMD_W-1:0] cmd,
    output logic                      in_ready,
    output logic                      out_valid,
    input  logic                      out_ready,
    output hpt_pkg::hpt_cmd_t         ctl
);
    import hpt_pkg::*;

    localparam int NW    = DATA_W + FRAC_BITS;
    localparam int CNT_W = $clog2(NW);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MAC   = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_DINIT = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_DFIN  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       di_reg, di_next;
    logic             pt_reg, pt_next;
    logic             ov_reg, ov_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        di_next    = di_reg;
        pt_next    = pt_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        ctl.mac_idx = cnt_reg[IDX_W-1:0];
        ctl.div_idx = di_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (cmd == CMD_LOAD)
                    begin
                        ctl.load = 1'b1;
                    end
                    else if (cmd == CMD_VECTOR || cmd == CMD_POINT)
                    begin
                        ctl.capture = 1'b1;
                        ctl.point   = (cmd == CMD_POINT);
                        pt_next     = (cmd == CMD_POINT);
                        cnt_next    = '0;
                        state_next  = S_MAC;
                    end
                end
            end
            S_MAC:
            begin
                ctl.mac_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(15))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                di_next    = '0;
                state_next = pt_reg ? S_DINIT : S_DONE;
            end
            S_DINIT:
            begin
                ctl.div_load = 1'b1;
                cnt_next     = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                ctl.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NW - 1))
                begin
                    state_next = S_DFIN;
                end
            end
            S_DFIN:
            begin
                ctl.div_write = 1'b1;
                di_next       = di_reg + 1'b1;
                state_next    = (di_reg == 2'd2) ? S_DONE : S_DINIT;
            end
            S_DONE:
            begin
                // wait for the output slot to free up
                if (!ov_reg || out_ready)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        ov_next = (ov_reg && !out_ready) || ctl.out_load;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            di_reg    <= '0;
            pt_reg    <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            di_reg    <= di_next;
            pt_reg    <= pt_next;
            ov_reg    <= ov_next;
        end
    end

    assign out_valid = ov_reg;

    `HPT_ASSERT(a_mac_len, clk, rst_n, (state_reg == S_MAC && cnt_reg == CNT_W'(15)) |=> (state_reg == S_DRAIN), "MAC phase length wrong")
    `HPT_NEVER(a_div_vec, clk, rst_n, (state_reg == S_DIV || state_reg == S_DINIT) && !pt_reg, "divide on vector item")
    `HPT_ASSERT(a_out_load, clk, rst_n, (state_reg == S_DONE && (!ov_reg || out_ready)) |=> (ov_reg && state_reg == S_IDLE), "result not handed off")

endmodule

### src/hpt_dp.sv
// ----------------------------------------------------------------------------
// hpt_dp
// Matrix store, shared multiply-accumulate, restoring divider, output register.
// ----------------------------------------------------------------------------
module hpt_dp #(
    parameter int FRAC_BITS = hpt_pkg::HPT_FRAC_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  hpt_pkg::hpt_cmd_t                 ctl,
    input  logic [hpt_pkg::IDX_W-1:0]         entry_index,
    input  logic signed [hpt_pkg::DATA_W-1:0] entry_value,
    input  logic signed [hpt_pkg::DATA_W-1:0] in_x,
    input  logic signed [hpt_pkg::DATA_W-1:0] in_y,
    input  logic signed [hpt_pkg::DATA_W-1:0] in_z,
    input  logic signed [hpt_pkg::DATA_W-1:0] in_w,
    output logic signed [hpt_pkg::DATA_W-1:0] out_x,
    output logic signed [hpt_pkg::DATA_W-1:0] out_y,
    output logic signed [hpt_pkg::DATA_W-1:0] out_z,
    output logic signed [hpt_pkg::DATA_W-1:0] out_w,
    output logic                              range_error
);
    import hpt_pkg::*;

    localparam int NW = DATA_W + FRAC_BITS;
    localparam logic signed [DATA_W-1:0] ONE_FX = DATA_W'(1) << FRAC_BITS;
    localparam logic signed [DATA_W-1:0] S_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] S_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    logic signed [DATA_W-1:0]   m_reg [16];
    logic signed [DATA_W-1:0]   v_reg [4];
    logic signed [DATA_W-1:0]   r_reg [4];
    logic signed [DATA_W-1:0]   o_reg [4];
    logic                       oerr_reg;
    logic                       err_reg;

    // multiply stage
    logic signed [2*DATA_W-1:0] prod_reg;
    logic                       pv_reg;
    logic [IDX_W-1:0]           pidx_reg;

    // accumulate stage
    logic signed [DATA_W+1:0]   acc_reg;
    logic signed [2*DATA_W-1:0] prod_sh;
    logic signed [DATA_W-1:0]   term;
    logic                       term_ovf;
    logic signed [DATA_W+1:0]   acc_sum;
    logic signed [DATA_W-1:0]   acc_sat;
    logic                       acc_ovf;

    // divider
    logic [NW-1:0]              num_reg;
    logic [DATA_W-1:0]          rem_reg;
    logic [DATA_W-1:0]          dm_reg;
    logic                       nneg_reg;
    logic                       dneg_reg;
    logic [DATA_W:0]            rem_sh;
    logic [DATA_W:0]            rem_sub;
    logic                       qbit;
    logic signed [DATA_W:0]     n_abs;
    logic signed [DATA_W:0]     d_abs;
    logic                       q_big;
    logic                       q_over;
    logic signed [DATA_W-1:0]   q_res;
    logic                       q_err;

    always_comb
    begin
        prod_sh  = prod_reg >>> FRAC_BITS;
        term_ovf = (prod_sh > 64'(S_MAX)) || (prod_sh < 64'(S_MIN));
        if (prod_sh > 64'(S_MAX))
        begin
            term = S_MAX;
        end
        else if (prod_sh < 64'(S_MIN))
        begin
            term = S_MIN;
        end
        else
        begin
            term = prod_sh[DATA_W-1:0];
        end
        acc_sum = ((pidx_reg[1:0] == 2'd0) ? '0 : acc_reg) + (DATA_W+2)'(term);
        acc_ovf = (acc_sum > (DATA_W+2)'(S_MAX)) || (acc_sum < (DATA_W+2)'(S_MIN));
        if (acc_sum > (DATA_W+2)'(S_MAX))
        begin
            acc_sat = S_MAX;
        end
        else if (acc_sum < (DATA_W+2)'(S_MIN))
        begin
            acc_sat = S_MIN;
        end
        else
        begin
            acc_sat = acc_sum[DATA_W-1:0];
        end
    end

    always_comb
    begin
        n_abs   = r_reg[ctl.div_idx][DATA_W-1] ? -(DATA_W+1)'(r_reg[ctl.div_idx])
                                                : (DATA_W+1)'(r_reg[ctl.div_idx]);
        d_abs   = r_reg[3][DATA_W-1] ? -(DATA_W+1)'(r_reg[3]) : (DATA_W+1)'(r_reg[3]);
        rem_sh  = {rem_reg, num_reg[NW-1]};
        rem_sub = rem_sh - {1'b0, dm_reg};
        qbit    = (rem_sh >= {1'b0, dm_reg});
        // quotient beyond 2^31 (negative limit) or beyond 2^31-1 (positive limit)
        q_big   = (num_reg[NW-1:DATA_W] != '0);
        q_over  = q_big || (num_reg[DATA_W-1] && (num_reg[DATA_W-2:0] != '0));
        q_err   = 1'b0;
        if (dm_reg == '0)
        begin
            q_err = 1'b1;
            q_res = nneg_reg ? S_MIN : S_MAX;
        end
        else if (nneg_reg != dneg_reg)
        begin
            if (q_over)
            begin
                q_err = 1'b1;
                q_res = S_MIN;
            end
            else
            begin
                q_res = -num_reg[DATA_W-1:0];
            end
        end
        else if (q_big || num_reg[DATA_W-1])
        begin
            q_err = 1'b1;
            q_res = S_MAX;
        end
        else
        begin
            q_res = num_reg[DATA_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= 1'b0;
        end
        else
        begin
            pv_reg <= ctl.mac_step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            m_reg[entry_index] <= entry_value;
        end
        if (ctl.capture)
        begin
            v_reg[0] <= in_x;
            v_reg[1] <= in_y;
            v_reg[2] <= in_z;
            v_reg[3] <= ctl.point ? ONE_FX : in_w;
        end
        if (ctl.mac_step)
        begin
            prod_reg <= 64'(m_reg[ctl.mac_idx]) * 64'(v_reg[ctl.mac_idx[1:0]]);
            pidx_reg <= ctl.mac_idx;
        end
        if (ctl.capture)
        begin
            err_reg <= 1'b0;
        end
        else if (pv_reg)
        begin
            acc_reg <= acc_sum;
            err_reg <= err_reg | term_ovf | ((pidx_reg[1:0] == 2'd3) & acc_ovf);
        end
        else if (ctl.div_write)
        begin
            err_reg <= err_reg | q_err;
        end
        if (pv_reg && pidx_reg[1:0] == 2'd3)
        begin
            r_reg[pidx_reg[3:2]] <= acc_sat;
        end
        if (ctl.div_load)
        begin
            num_reg  <= {n_abs[DATA_W-1:0], {FRAC_BITS{1'b0}}};
            rem_reg  <= '0;
            dm_reg   <= d_abs[DATA_W-1:0];
            nneg_reg <= r_reg[ctl.div_idx][DATA_W-1];
            dneg_reg <= r_reg[3][DATA_W-1];
        end
        else if (ctl.div_step)
        begin
            rem_reg <= qbit ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
            num_reg <= {num_reg[NW-2:0], qbit};
        end
        if (ctl.div_write)
        begin
            r_reg[ctl.div_idx] <= q_res;
        end
        if (ctl.out_load)
        begin
            o_reg    <= r_reg;
            oerr_reg <= err_reg;
        end
    end

    assign out_x       = o_reg[0];
    assign out_y       = o_reg[1];
    assign out_z       = o_reg[2];
    assign out_w       = o_reg[3];
    assign range_error = oerr_reg;

endmodule

### src/homogeneous_point_transform.sv
// Vector items run the multiply-accumulate only, point items add three divides by w;
// a load item only writes one matrix entry and gives no result.
// The single multiply-accumulate (16 steps) and the 1-bit-per-cycle divider
// (three quotients) set the item time; one item is in work at a time.
// Reset clears control state; the matrix store is undefined until loaded.
// ----------------------------------------------------------------------------
// homogeneous_point_transform
// 4x4 fixed-point matrix transform of vectors and points with w divide.
// ----------------------------------------------------------------------------
module homogeneous_point_transform #(
    parameter int FRAC_BITS = hpt_pkg::HPT_FRAC_BITS
) (
    input  logic  clk,
    input  logic  rst_n,
    hpt_in_if.sink    in_ch,
    hpt_out_if.source out_ch
);
    import hpt_pkg::*;

    hpt_cmd_t ctl;

    hpt_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .cmd       (in_ch.cmd),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .ctl       (ctl)
    );

    hpt_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .entry_index (in_ch.entry_index),
        .entry_value (in_ch.entry_value),
        .in_x        (in_ch.in_x),
        .in_y        (in_ch.in_y),
        .in_z        (in_ch.in_z),
        .in_w        (in_ch.in_w),
        .out_x       (out_ch.out_x),
        .out_y       (out_ch.out_y),
        .out_z       (out_ch.out_z),
        .out_w       (out_ch.out_w),
        .range_error (out_ch.range_error)
    );

endmodule

### bench/hpt_checker.sv
// ----------------------------------------------------------------------------
// hpt_checker
// Watches both channels of the point transform. It keeps its own copy of the
// matrix and predicts each vector and point result. Each accepted result is
// compared field by field with the oldest expectation.
// ----------------------------------------------------------------------------
module hpt_checker (
    input  logic       clk,
    input  logic       rst_n,
    hpt_in_if          in_ch,
    hpt_out_if         out_ch,
    output int         fail_count,
    output int         pending,
    output int         vector_count,
    output int         point_count,
    output int         saturated_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import hpt_pkg::*;

    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;

    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] z;
        logic signed [DATA_W-1:0] w;
        logic                     range_error;
    } hpt_result_t;

    logic signed [DATA_W-1:0] matrix [16];
    hpt_result_t              expected_results [$];

    assign pending = expected_results.size();

    function automatic longint clamp32(input longint v, inout logic err);
        if (v > S32_MAX)
        begin
            err = 1'b1;
            return S32_MAX;
        end
        if (v < S32_MIN)
        begin
            err = 1'b1;
            return S32_MIN;
        end
        return v;
    endfunction

    // Arithmetic shift of a signed value floors, as the product rounding wants.
    function automatic longint fixed_mul(input longint a, input longint b, inout logic err);
        longint p;
        p = a * b;
        return clamp32(p >>> HPT_FRAC_BITS, err);
    endfunction

    function automatic longint fixed_div(input longint n, input longint d, inout logic err);
        longint unsigned nm;
        longint unsigned dm;
        longint unsigned q;
        logic            neg;
        if (d == 0)
        begin
            err = 1'b1;
            return (n < 0) ? S32_MIN : S32_MAX;
        end
        neg = (n < 0) != (d < 0);
        nm  = longint'(n < 0 ? -n : n) << HPT_FRAC_BITS;
        dm  = longint'(d < 0 ? -d : d);
        q   = nm / dm;
        if (neg)
        begin
            if (q > 64'd2147483648)
            begin
                err = 1'b1;
                return S32_MIN;
            end
            return -longint'(q);
        end
        if (q > 64'd2147483647)
        begin
            err = 1'b1;
            return S32_MAX;
        end
        return longint'(q);
    endfunction

    function automatic hpt_result_t transform_vertex(input logic [CMD_W-1:0] cmd,
                                                     input longint vx, input longint vy,
                                                     input longint vz, input longint vw);
        longint      v [4];
        longint      r [4];
        longint      acc;
        logic        err;
        hpt_result_t res;
        err  = 1'b0;
        v[0] = vx;
        v[1] = vy;
        v[2] = vz;
        v[3] = (cmd == CMD_POINT) ? (64'sd1 <<< HPT_FRAC_BITS) : vw;
        for (int row = 0; row < 4; row++)
        begin
            acc = 0;
            for (int col = 0; col < 4; col++)
                acc += fixed_mul(longint'(matrix[row*4+col]), v[col], err);
            r[row] = clamp32(acc, err);
        end
        if (cmd == CMD_POINT)
            for (int i = 0; i < 3; i++)
                r[i] = fixed_div(r[i], r[3], err);
        res.x           = r[0][DATA_W-1:0];
        res.y           = r[1][DATA_W-1:0];
        res.z           = r[2][DATA_W-1:0];
        res.w           = r[3][DATA_W-1:0];
        res.range_error = err;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        hpt_result_t got;
        hpt_result_t exp_res;
        if (!rst_n)
        begin
            fail_count      <= 0;
            vector_count    <= 0;
            point_count     <= 0;
            saturated_count <= 0;
            expected_results.delete();
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got = {out_ch.out_x, out_ch.out_y, out_ch.out_z, out_ch.out_w,
                       out_ch.range_error};
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result with nothing expected: %h", $time, got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_res = expected_results.pop_front();
                    if (got.range_error)
                        saturated_count <= saturated_count + 1;
                    if (got !== exp_res)
                    begin
                        $display("%0t: mismatch x exp %h got %h, y exp %h got %h",
                                 $time, exp_res.x, got.x, exp_res.y, got.y);
                        $display("%0t:          z exp %h got %h, w exp %h got %h, err exp %b got %b",
                                 $time, exp_res.z, got.z, exp_res.w, got.w,
                                 exp_res.range_error, got.range_error);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                case (in_ch.cmd)
                    CMD_LOAD:
                        matrix[in_ch.entry_index] = in_ch.entry_value;
                    CMD_VECTOR, CMD_POINT:
                    begin
                        expected_results.push_back(transform_vertex(in_ch.cmd,
                            longint'(in_ch.in_x), longint'(in_ch.in_y),
                            longint'(in_ch.in_z), longint'(in_ch.in_w)));
                        if (in_ch.cmd == CMD_POINT)
                            point_count <= point_count + 1;
                        else
                            vector_count <= vector_count + 1;
                    end
                    default:
                        ; // unused command: drop
                endcase
            end
        end
    end
endmodule

### bench/tb_homogeneous_point_transform.sv
// ----------------------------------------------------------------------------
// tb_homogeneous_point_transform
// Drives loads, vector and point transforms with random gaps and stalls into
// the point transform; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_homogeneous_point_transform;
    timeunit 1ns;
    timeprecision 1ps;
    import hpt_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;
    localparam int               CYCLE_LIMIT = 2000000;
    localparam int               CALM_FROM   = 30000;
    localparam int               CALM_TO     = 45000;
    localparam int               HOLD_AT     = 8000;
    localparam int               HOLD_LEN    = 1500;

    logic clk;
    logic rst_n;
    int   cycle = 0;
    int   fail_count;
    int   pending;
    int   vector_count;
    int   point_count;
    int   saturated_count;

    hpt_in_if  in_ch ();
    hpt_out_if out_ch ();

    homogeneous_point_transform dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    hpt_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_ch           (in_ch),
        .out_ch          (out_ch),
        .fail_count      (fail_count),
        .pending         (pending),
        .vector_count    (vector_count),
        .point_count     (point_count),
        .saturated_count (saturated_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic bit calm();
        return cycle >= CALM_FROM && cycle < CALM_TO;
    endfunction

    // Receiver: random stalls, one long hold-off so the input backs up.
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (cycle >= HOLD_AT && cycle < HOLD_AT + HOLD_LEN)
                out_ch.ready = 1'b0;
            else
                out_ch.ready = calm() || ($urandom_range(99) >= 23);
        end
    end

    task automatic send(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                        input logic [31:0] val, input logic [31:0] x, input logic [31:0] y,
                        input logic [31:0] z, input logic [31:0] w);
        while (!calm() && $urandom_range(99) < 23)
        begin
            @(negedge clk);
            in_ch.valid = 1'b0;
        end
        @(negedge clk);
        in_ch.valid       = 1'b1;
        in_ch.cmd         = cmd;
        in_ch.entry_index = idx;
        in_ch.entry_value = val;
        in_ch.in_x        = x;
        in_ch.in_y        = y;
        in_ch.in_z        = z;
        in_ch.in_w        = w;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    // Mostly modest Q16.16 values, with extremes and raw 32-bit noise mixed in.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3:    return $urandom;
            4:       return 32'h0001_0000;
            default: return 32'($signed($urandom_range(16*65536)) - 8*65536);
        endcase
    endfunction

    function automatic logic [31:0] pick_entry();
        return ($urandom_range(7) == 0) ? pick_value()
                                        : 32'($signed($urandom_range(4*65536)) - 2*65536);
    endfunction

    initial
    begin
        int kind;
        rst_n             = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.cmd         = CMD_LOAD;
        in_ch.entry_index = '0;
        in_ch.entry_value = '0;
        in_ch.in_x        = '0;
        in_ch.in_y        = '0;
        in_ch.in_z        = '0;
        in_ch.in_w        = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Identity matrix first, with the two extreme entries off the diagonal.
        for (int i = 0; i < 16; i++)
            send(CMD_LOAD, i[3:0],
                 (i == 1) ? 32'h7FFF_FFFF : (i == 6) ? 32'h8000_0000 :
                 (i % 5 == 0) ? 32'h0001_0000 : 32'h0, '0, '0, '0, '0);
        send(CMD_VECTOR, '0, '0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0002_0000, 32'h8000_0000);
        send(CMD_VECTOR, '0, '0, 32'h0, 32'h0, 32'h0, 32'h0);
        send(CMD_POINT, '0, '0, 32'h0003_0000, 32'h0, 32'hFFFE_0000, 32'h1234_5678);
        send(CMD_UNUSED, 4'hF, 32'hFFFF_FFFF, '1, '1, '1, '1);
        // Zero the bottom row so a point sees a zero w.
        for (int i = 12; i < 16; i++)
            send(CMD_LOAD, i[3:0], 32'h0, '0, '0, '0, '0);
        send(CMD_POINT, '0, '0, 32'h0001_0000, 32'h0, 32'hFFFF_0000, 32'h0);

        for (int n = 0; n < 600; n++)
        begin
            kind = $urandom_range(99);
            if (kind < 30)
                send(CMD_LOAD, 4'($urandom), pick_entry(), $urandom, $urandom, $urandom,
                     $urandom);
            else if (kind < 62)
                send(CMD_VECTOR, 4'($urandom), $urandom, pick_value(), pick_value(),
                     pick_value(), pick_value());
            else if (kind < 97)
                send(CMD_POINT, 4'($urandom), $urandom, pick_value(), pick_value(),
                     pick_value(), $urandom);
            else
                send(CMD_UNUSED, 4'($urandom), $urandom, $urandom, $urandom, $urandom,
                     $urandom);
        end
        @(negedge clk);
        in_ch.valid = 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);

        $display("Covered %0d vector and %0d point transforms, %0d flagged out of range.",
                 vector_count, point_count, saturated_count);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
